>>> sv/rdd_pkg.sv
// types and constants shared by the deduplication directory
`default_nettype none

package rdd_pkg;

	localparam int KEY_W    = 64;
	localparam int OFFSET_W = 48;
	localparam int SIZE_W   = 32;
	localparam int REFS_W   = 32;

	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [OFFSET_W-1:0] offset_t;
	typedef logic [SIZE_W-1:0]   size_t;
	typedef logic [REFS_W-1:0]   refs_t;

	localparam refs_t REFS_MAX = '1;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_RAISED    = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		op_t   operation;
		key_t  content_key;
		size_t item_size;
	} req_t;

	typedef struct packed {
		status_t status;
		logic    found;
		offset_t entry_offset;
		size_t   entry_size;
		refs_t   entry_refs;
	} rsp_t;

endpackage

`default_nettype wire

>>> sv/rdd_stream_if.sv
// valid/ready channel carrying one transaction payload
`default_nettype none

interface rdd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/refcounted_dedup_directory.sv
// requests taken wait in the input register, results in the result register
// throughput: one request per cycle unless a held result stalls the output;
// the key match over all entries runs in parallel between the two registers
// reset: valid marks, offset cursor and channel valids clear at once;
// entry contents are not reset and no clearing pass is needed
`default_nettype none

module refcounted_dedup_directory #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	rdd_stream_if.sink   req,
	rdd_stream_if.source rsp
);

	typedef logic [TABLE_ENTRIES-1:0] vec_t;

	// entry storage
	vec_t                slot_valid_q;
	rdd_pkg::key_t       slot_key_q    [TABLE_ENTRIES];
	rdd_pkg::offset_t    slot_offset_q [TABLE_ENTRIES];
	rdd_pkg::size_t      slot_size_q   [TABLE_ENTRIES];
	rdd_pkg::refs_t      slot_refs_q   [TABLE_ENTRIES];
	rdd_pkg::offset_t    next_offset_q;

	// input stage
	logic                valid_s1;
	rdd_pkg::req_t       req_s1;

	// result register
	logic                rsp_valid_q;
	rdd_pkg::rsp_t       rsp_q;

	logic                advance;
	vec_t                match_vec;
	vec_t                hit_oh;
	vec_t                free_vec;
	vec_t                free_oh;
	logic                hit_any;
	logic                free_any;
	rdd_pkg::offset_t    hit_offset;
	rdd_pkg::size_t      hit_size;
	rdd_pkg::refs_t      hit_refs;
	rdd_pkg::refs_t      refs_inc;
	rdd_pkg::refs_t      refs_dec;
	logic                alloc_en;
	logic                raise_en;
	logic                drop_en;
	rdd_pkg::rsp_t       rsp_d;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	// parallel match and lowest-index selection
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match_vec[i] = slot_valid_q[i] && (slot_key_q[i] == req_s1.content_key);
		end
	end

	assign free_vec = ~slot_valid_q;
	assign hit_oh   = match_vec & (~match_vec + TABLE_ENTRIES'(1));
	assign free_oh  = free_vec & (~free_vec + TABLE_ENTRIES'(1));
	assign hit_any  = |match_vec;
	assign free_any = |free_vec;

	always_comb begin
		hit_offset = '0;
		hit_size   = '0;
		hit_refs   = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (hit_oh[i]) begin
				hit_offset = hit_offset | slot_offset_q[i];
				hit_size   = hit_size | slot_size_q[i];
				hit_refs   = hit_refs | slot_refs_q[i];
			end
		end
	end

	assign refs_inc = (hit_refs == rdd_pkg::REFS_MAX) ? hit_refs
		: hit_refs + rdd_pkg::REFS_W'(1);
	assign refs_dec = (hit_refs == '0) ? hit_refs : hit_refs - rdd_pkg::REFS_W'(1);

	assign raise_en = advance && (req_s1.operation == rdd_pkg::OP_ADD) && hit_any;
	assign alloc_en = advance && (req_s1.operation == rdd_pkg::OP_ADD) && !hit_any
		&& free_any;
	assign drop_en  = advance && (req_s1.operation == rdd_pkg::OP_REMOVE) && hit_any;

	always_comb begin
		rsp_d.status       = rdd_pkg::ST_NOT_FOUND;
		rsp_d.found        = 1'b0;
		rsp_d.entry_offset = '0;
		rsp_d.entry_size   = '0;
		rsp_d.entry_refs   = '0;
		case (req_s1.operation)
			rdd_pkg::OP_ADD: begin
				if (hit_any) begin
					rsp_d.status       = rdd_pkg::ST_RAISED;
					rsp_d.found        = 1'b1;
					rsp_d.entry_offset = hit_offset;
					rsp_d.entry_size   = hit_size;
					rsp_d.entry_refs   = refs_inc;
				end else if (free_any) begin
					rsp_d.status       = rdd_pkg::ST_DONE;
					rsp_d.entry_offset = next_offset_q;
					rsp_d.entry_size   = req_s1.item_size;
					rsp_d.entry_refs   = rdd_pkg::REFS_W'(1);
				end else begin
					rsp_d.status       = rdd_pkg::ST_FULL;
				end
			end
			rdd_pkg::OP_LOOKUP: begin
				if (hit_any) begin
					rsp_d.status       = rdd_pkg::ST_DONE;
					rsp_d.found        = 1'b1;
					rsp_d.entry_offset = hit_offset;
					rsp_d.entry_size   = hit_size;
					rsp_d.entry_refs   = hit_refs;
				end
			end
			rdd_pkg::OP_REMOVE: begin
				if (hit_any) begin
					rsp_d.status       = rdd_pkg::ST_DONE;
					rsp_d.found        = 1'b1;
					rsp_d.entry_offset = hit_offset;
					rsp_d.entry_size   = hit_size;
					rsp_d.entry_refs   = refs_dec;
				end
			end
			default: begin
				rsp_d.status = rdd_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q  <= '0;
			next_offset_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (alloc_en) begin
				slot_valid_q  <= slot_valid_q | free_oh;
				next_offset_q <= next_offset_q + rdd_pkg::OFFSET_W'(req_s1.item_size);
			end else if (drop_en && (refs_dec == '0)) begin
				slot_valid_q  <= slot_valid_q & ~hit_oh;
			end
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (alloc_en && free_oh[i]) begin
				slot_key_q[i]    <= req_s1.content_key;
				slot_offset_q[i] <= next_offset_q;
				slot_size_q[i]   <= req_s1.item_size;
				slot_refs_q[i]   <= rdd_pkg::REFS_W'(1);
			end else if (raise_en && hit_oh[i]) begin
				slot_refs_q[i]   <= refs_inc;
			end else if (drop_en && hit_oh[i]) begin
				slot_refs_q[i]   <= refs_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

`ifndef SYNTHESIS
	// a key is never held twice
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(match_vec))
		else $error("key matched in more than one entry");

	// the cursor moves only when a new entry is placed
	a_cursor_moves_on_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(next_offset_q != $past(next_offset_q)) |-> $past(alloc_en))
		else $error("offset cursor moved without an allocation");

	// a present key never reports not found or full
	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.found |->
		(rsp_q.status == rdd_pkg::ST_DONE || rsp_q.status == rdd_pkg::ST_RAISED))
		else $error("found result with a failure status");

	// a result taken with nothing behind it leaves the output empty
	a_result_drains: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp.ready && !advance |=> !rsp_valid_q)
		else $error("result repeated after transaction");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_refcounted_dedup_directory.sv
// testbench of the deduplication directory: queued requests checked against a predicted directory
`timescale 1ns / 1ps

module tb_refcounted_dedup_directory;

	localparam int TABLE_ENTRIES = 64;
	localparam int KEY_POOL_N = 100;
	localparam int RANDOM_ITEMS = 1000;
	localparam int REUSE_PAIRS = 200;
	localparam rdd_pkg::op_t OP_UNUSED = rdd_pkg::op_t'(2'd3);
	localparam rdd_pkg::key_t REUSE_KEY = 64'h0F1E_2D3C_4B5A_6978;

	typedef struct {
		rdd_pkg::req_t req;
		bit            drain;
		bit            steady;
	} req_item_t;

	logic clk;
	logic arst_n;

	rdd_stream_if #(.payload_t(rdd_pkg::req_t)) req_if ();
	rdd_stream_if #(.payload_t(rdd_pkg::rsp_t)) rsp_if ();

	refcounted_dedup_directory #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	req_item_t     req_backlog[$];
	rdd_pkg::rsp_t predicted_rsp[$];
	rdd_pkg::key_t key_pool[KEY_POOL_N];

	// predicted directory contents
	logic [TABLE_ENTRIES-1:0] dir_valid;
	rdd_pkg::key_t    dir_key[TABLE_ENTRIES];
	rdd_pkg::offset_t dir_offset[TABLE_ENTRIES];
	rdd_pkg::size_t   dir_size[TABLE_ENTRIES];
	rdd_pkg::refs_t   dir_refs[TABLE_ENTRIES];
	rdd_pkg::offset_t dir_cursor;

	int unsigned     gap_left;
	int unsigned     stall_left;
	int              in_flight;
	int              taken_n;
	int              total_items;
	int              steady_items;
	int              mismatches;
	bit              steady;
	rdd_pkg::rsp_t   want_rsp;
	longint unsigned cycle_count;
	longint unsigned limit_cycles;

	wire req_take = req_if.valid && req_if.ready;
	wire rsp_take = rsp_if.valid && rsp_if.ready;
	wire calm = (cycle_count[10:9] == 2'b00);

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic rdd_pkg::rsp_t directory_update(input rdd_pkg::req_t r);
		int            hit;
		int            vacant;
		rdd_pkg::rsp_t o;
		hit = -1;
		vacant = -1;
		o = '0;
		o.status = rdd_pkg::ST_NOT_FOUND;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (dir_valid[i] && dir_key[i] == r.content_key)
				hit = i;
			if (!dir_valid[i])
				vacant = i;
		end
		case (r.operation)
			rdd_pkg::OP_ADD: begin
				if (hit >= 0) begin
					if (dir_refs[hit] != rdd_pkg::REFS_MAX)
						dir_refs[hit] = dir_refs[hit] + 1'b1;
					o = '{rdd_pkg::ST_RAISED, 1'b1, dir_offset[hit], dir_size[hit],
						dir_refs[hit]};
				end else if (vacant < 0) begin
					o.status = rdd_pkg::ST_FULL;
				end else begin
					dir_valid[vacant] = 1'b1;
					dir_key[vacant] = r.content_key;
					dir_offset[vacant] = dir_cursor;
					dir_size[vacant] = r.item_size;
					dir_refs[vacant] = rdd_pkg::refs_t'(1);
					o = '{rdd_pkg::ST_DONE, 1'b0, dir_cursor, r.item_size,
						rdd_pkg::refs_t'(1)};
					dir_cursor = dir_cursor + rdd_pkg::offset_t'(r.item_size);
				end
			end
			rdd_pkg::OP_LOOKUP: begin
				if (hit >= 0)
					o = '{rdd_pkg::ST_DONE, 1'b1, dir_offset[hit], dir_size[hit],
						dir_refs[hit]};
			end
			rdd_pkg::OP_REMOVE: begin
				if (hit >= 0) begin
					if (dir_refs[hit] != '0)
						dir_refs[hit] = dir_refs[hit] - 1'b1;
					if (dir_refs[hit] == '0)
						dir_valid[hit] = 1'b0;
					o = '{rdd_pkg::ST_DONE, 1'b1, dir_offset[hit], dir_size[hit],
						dir_refs[hit]};
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	task automatic queue_req(input rdd_pkg::op_t op, input rdd_pkg::key_t key,
			input rdd_pkg::size_t size, input bit drain = 1'b0, input bit hold = 1'b0);
		req_item_t item;
		item.req = '{op, key, size};
		item.drain = drain;
		item.steady = hold;
		req_backlog.push_back(item);
		if (hold)
			steady_items++;
	endtask

	task automatic flag_field(input string field, input logic [63:0] want,
			input logic [63:0] seen);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count >= limit_cycles) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.data <= '0;
			gap_left <= 0;
			steady <= 1'b0;
		end else if (!req_if.valid || req_if.ready) begin
			if (gap_left != 0) begin
				req_if.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (req_backlog.size() != 0 &&
					!(req_backlog[0].drain && (in_flight != 0 || req_if.valid))) begin
				req_if.valid <= 1'b1;
				req_if.data <= req_backlog[0].req;
				steady <= req_backlog[0].steady;
				gap_left <= (req_backlog[0].steady || calm) ? 0 : pick_gap();
				void'(req_backlog.pop_front());
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// response back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			rsp_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && !steady && $urandom_range(0, 3) == 0) begin
			rsp_if.ready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// monitor: check the response transaction first, then predict the request taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight <= 0;
			taken_n <= 0;
			dir_valid = '0;
			dir_cursor = '0;
		end else begin
			if (rsp_take) begin
				if (predicted_rsp.size() == 0) begin
					$display("%0t: unexpected response %p", $time, rsp_if.data);
					mismatches++;
				end else begin
					want_rsp = predicted_rsp.pop_front();
					if (rsp_if.data.status !== want_rsp.status)
						flag_field("status", want_rsp.status, rsp_if.data.status);
					if (rsp_if.data.found !== want_rsp.found)
						flag_field("found", want_rsp.found, rsp_if.data.found);
					if (rsp_if.data.entry_offset !== want_rsp.entry_offset)
						flag_field("entry_offset", want_rsp.entry_offset,
							rsp_if.data.entry_offset);
					if (rsp_if.data.entry_size !== want_rsp.entry_size)
						flag_field("entry_size", want_rsp.entry_size, rsp_if.data.entry_size);
					if (rsp_if.data.entry_refs !== want_rsp.entry_refs)
						flag_field("entry_refs", want_rsp.entry_refs, rsp_if.data.entry_refs);
				end
			end
			if (req_take) begin
				predicted_rsp.push_back(directory_update(req_if.data));
				taken_n <= taken_n + 1;
			end
			in_flight <= in_flight + (req_take ? 1 : 0) - (rsp_take ? 1 : 0);
		end
	end

	initial begin
		int             random_n;
		int             round_len;
		int             pool_n;
		int             r;
		rdd_pkg::op_t   op;
		rdd_pkg::key_t  key;
		rdd_pkg::size_t size;

		arst_n = 1'b0;
		mismatches = 0;
		steady_items = 0;
		limit_cycles = 64'd1000000;

		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 64'hAAAA_AAAA_AAAA_AAAA;
		key_pool[3] = 64'h5555_5555_5555_5555;
		key_pool[4] = 64'h8000_0000_0000_0000;
		key_pool[5] = 64'h0000_0000_0000_0001;
		for (int i = 6; i < KEY_POOL_N; i++)
			key_pool[i] = {$urandom, $urandom};

		// empty directory, field extremes, count up and down, unused code
		queue_req(rdd_pkg::OP_LOOKUP, key_pool[0], '0);
		queue_req(rdd_pkg::OP_REMOVE, key_pool[1], '1);
		queue_req(OP_UNUSED, key_pool[5], '1);
		queue_req(rdd_pkg::OP_ADD, key_pool[0], '0);
		queue_req(rdd_pkg::OP_ADD, key_pool[1], '1);
		queue_req(rdd_pkg::OP_ADD, key_pool[0], 32'h1234_5678);
		queue_req(rdd_pkg::OP_LOOKUP, key_pool[0], '0);
		queue_req(rdd_pkg::OP_LOOKUP, key_pool[1], '1);
		queue_req(rdd_pkg::OP_ADD, key_pool[2], 32'h5555_5555);
		queue_req(rdd_pkg::OP_ADD, key_pool[3], 32'hAAAA_AAAA);
		queue_req(rdd_pkg::OP_REMOVE, key_pool[0], '0);
		queue_req(rdd_pkg::OP_REMOVE, key_pool[0], '0);
		queue_req(rdd_pkg::OP_LOOKUP, key_pool[0], '0);
		queue_req(rdd_pkg::OP_REMOVE, key_pool[0], '0);
		queue_req(OP_UNUSED, key_pool[1], '0);
		queue_req(rdd_pkg::OP_LOOKUP, key_pool[1], '0);
		queue_req(rdd_pkg::OP_ADD, key_pool[0], 32'h0000_0001);
		queue_req(rdd_pkg::OP_ADD, key_pool[4], 32'h8000_0000);
		queue_req(rdd_pkg::OP_ADD, key_pool[5], 32'h0000_0001, 1'b1);
		queue_req(rdd_pkg::OP_LOOKUP, key_pool[4], '0);

		// place and free one key again and again with the largest size
		for (int i = 0; i < REUSE_PAIRS; i++) begin
			queue_req(rdd_pkg::OP_ADD, REUSE_KEY, '1, i == 0, 1'b1);
			queue_req(rdd_pkg::OP_REMOVE, REUSE_KEY, '0, 1'b0, 1'b1);
		end
		queue_req(rdd_pkg::OP_LOOKUP, REUSE_KEY, '0);

		// fill the table, then overflow it
		for (int i = 6; i < 70; i++)
			queue_req(rdd_pkg::OP_ADD, key_pool[i], $urandom);
		queue_req(rdd_pkg::OP_LOOKUP, key_pool[69], '0);
		queue_req(rdd_pkg::OP_REMOVE, key_pool[6], '0);
		queue_req(rdd_pkg::OP_ADD, key_pool[69], $urandom);
		queue_req(rdd_pkg::OP_ADD, key_pool[70], $urandom);
		queue_req(rdd_pkg::OP_LOOKUP, key_pool[69], '0);

		random_n = 0;
		while (random_n < RANDOM_ITEMS) begin
			round_len = $urandom_range(50, 250);
			pool_n = $urandom_range(0, 1) ? $urandom_range(2, 16)
				: $urandom_range(60, KEY_POOL_N);
			for (int j = 0; j < round_len; j++) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					op = rdd_pkg::OP_ADD;
				else if (r < 60)
					op = rdd_pkg::OP_LOOKUP;
				else if (r < 95)
					op = rdd_pkg::OP_REMOVE;
				else
					op = OP_UNUSED;
				if ($urandom_range(0, 19) == 0)
					key = {$urandom, $urandom};
				else
					key = key_pool[$urandom_range(0, pool_n - 1)];
				case ($urandom_range(0, 9))
					0: size = '0;
					1: size = '1;
					2: size = $urandom_range(1, 16);
					default: size = $urandom;
				endcase
				queue_req(op, key, size, j == 0 && $urandom_range(0, 3) == 0);
			end
			random_n += round_len;
		end

		total_items = req_backlog.size();
		limit_cycles = 4 * (longint'(steady_items) * 4 +
			longint'(total_items - steady_items) * 84) + 10000;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (taken_n != total_items || in_flight != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (predicted_rsp.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, predicted_rsp.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
